>>> hw/rtl/frc_pkg.sv
`timescale 1ns / 1ps
package frc_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 5;
  localparam int TICK_W   = 16;
  localparam int CRC_W    = 16;

  // Default frame buffer depth in bytes
  localparam int FRAME_BYTES_DEF = 32;

  // Frame start markers
  localparam logic [BYTE_W-1:0] START_A = 8'hDC;
  localparam logic [BYTE_W-1:0] START_B = 8'hDE;

  // Position of the length byte, counted from one
  localparam int LEN_POS = 4;

  // Idle timeout after reset
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd5000;

  // CRC-16/XMODEM polynomial
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_START = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CRC_BAD   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_GOOD      = 3'd4;

  // Fold one byte into the CRC, MSB first
  function automatic logic [CRC_W-1:0] crc_add(input logic [CRC_W-1:0] crc_in,
                                               input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/frc_if.sv
`timescale 1ns / 1ps
// Input word: one received byte or one time tick
interface frc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [frc_pkg::BYTE_W-1:0]  data_byte;

  modport source(output valid, output mode, output data_byte, input ready);
  modport sink(input valid, input mode, input data_byte, output ready);
endinterface

// Output word: one status or one byte of a good frame
interface frc_out_if;
  logic                         valid;
  logic                         ready;
  logic [frc_pkg::STATUS_W-1:0] status;
  logic [frc_pkg::BYTE_W-1:0]   frame_byte;
  logic [frc_pkg::INDEX_W-1:0]  byte_index;
  logic                         last;

  modport source(output valid, output status, output frame_byte, output byte_index,
                 output last, input ready);
  modport sink(input valid, input status, input frame_byte, input byte_index,
               input last, output ready);
endinterface

>>> hw/rtl/frc_cell.sv
`timescale 1ns / 1ps
module frc_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [frc_pkg::BYTE_W-1:0] din,
  output logic [frc_pkg::BYTE_W-1:0] dout
);

  // Take the neighbor's byte on every shift
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

>>> hw/rtl/frc_chain.sv
`timescale 1ns / 1ps
module frc_chain #(
  parameter int DEPTH = frc_pkg::FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [frc_pkg::BYTE_W-1:0] din,
  input  logic [$clog2(DEPTH)-1:0]   tap,
  output logic [frc_pkg::BYTE_W-1:0] dout
);

  logic [frc_pkg::BYTE_W-1:0] cell_q [DEPTH];

  // Newest byte enters cell 0; older bytes move toward the far end
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      frc_cell u_cell (.clk(clk), .shift(shift), .din(din), .dout(cell_q[i]));
    end else begin : g_body
      frc_cell u_cell (.clk(clk), .shift(shift), .din(cell_q[i-1]), .dout(cell_q[i]));
    end
  end

  // Oldest byte of the frame sits at the tap
  assign dout = cell_q[tap];

endmodule

>>> hw/rtl/bus_frame_receiver_crc_check.sv
`timescale 1ns / 1ps
// Bus frame receiver with CRC-16/XMODEM check.
// in_ch carries one word per received byte (mode 0) or per microsecond tick
// (mode 1). out_ch gives one status word per byte (last set); ticks give none.
// A frame starts with 0xDC or 0xDE, its fourth byte is the length, and when
// the length is reached the CRC residue over the whole frame must be zero.
// A good frame leaves as a run of status-4 words, one per byte, last on the
// final one. The user must write timeout_ticks through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce it. The status
// word of a byte that does not close a good frame is valid the cycle after
// that byte is taken. A good frame streams out from the cell row, one cell
// shift per word, while in_ch is held off.
// Reset clears the frame, idle count and CRC, and loads timeout_ticks with
// 5000. When out_ch stalls, the output register holds its word, the frame
// stream pauses, and in_ch drops ready until the register can take more.
module bus_frame_receiver_crc_check #(
  parameter int FRAME_BYTES = frc_pkg::FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [frc_pkg::TICK_W-1:0] cfg_wdata,
  frc_in_if.sink                     in_ch,
  frc_out_if.source                  out_ch
);

  localparam int         FILL_W    = $clog2(FRAME_BYTES + 1);
  localparam int         TAP_W     = $clog2(FRAME_BYTES);
  localparam logic [8:0] LEN_LIMIT = 9'(FRAME_BYTES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic                         state;
  logic [FILL_W-1:0]            fill_count;
  logic [frc_pkg::TICK_W-1:0]   idle_count;
  logic [frc_pkg::CRC_W-1:0]    running_crc;
  logic [frc_pkg::BYTE_W-1:0]   len_reg;
  logic [frc_pkg::TICK_W-1:0]   timeout_ticks;
  logic [TAP_W-1:0]             tap;
  logic [TAP_W-1:0]             emit_idx;
  logic                         out_valid;
  logic [frc_pkg::STATUS_W-1:0] out_status;
  logic [frc_pkg::BYTE_W-1:0]   out_byte;
  logic [frc_pkg::INDEX_W-1:0]  out_index;
  logic                         out_last;

  logic                         slot_free;
  logic                         accept;
  logic                         byte_in;
  logic                         tick_in;
  logic                         emit_step;
  logic                         is_start;
  logic [FILL_W-1:0]            fill_eff;
  logic [FILL_W-1:0]            fill_inc;
  logic [frc_pkg::CRC_W-1:0]    crc_base;
  logic [frc_pkg::CRC_W-1:0]    crc_new;
  logic [frc_pkg::BYTE_W-1:0]   len_eff;
  logic [FILL_W-1:0]            fill_next;
  logic [frc_pkg::CRC_W-1:0]    crc_next;
  logic [frc_pkg::BYTE_W-1:0]   len_next;
  logic [frc_pkg::STATUS_W-1:0] byte_status;
  logic                         good;
  logic                         chain_shift;
  logic [frc_pkg::BYTE_W-1:0]   chain_din;
  logic [frc_pkg::BYTE_W-1:0]   chain_dout;

  // Handshake: take a word only with the output register free and no frame streaming
  assign slot_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && slot_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign byte_in = accept && !in_ch.mode;
  assign tick_in = accept && in_ch.mode;
  assign emit_step = (state == S_EMIT) && slot_free;

  // Drop a stale partial frame, then fold in the new byte
  assign is_start = (in_ch.data_byte == frc_pkg::START_A) ||
                    (in_ch.data_byte == frc_pkg::START_B);
  assign fill_eff = ((fill_count != '0) && (idle_count > timeout_ticks)) ? '0 : fill_count;
  assign fill_inc = fill_eff + 1'b1;
  assign crc_base = (fill_eff == '0) ? '0 : running_crc;
  assign crc_new  = frc_pkg::crc_add(crc_base, in_ch.data_byte);
  assign len_eff  = (fill_inc == FILL_W'(frc_pkg::LEN_POS)) ? in_ch.data_byte : len_reg;

  // Decide the outcome of one byte
  always_comb begin
    fill_next   = fill_count;
    crc_next    = running_crc;
    len_next    = len_reg;
    byte_status = frc_pkg::ST_TAKEN;
    good        = 1'b0;
    if ((fill_eff == '0) && !is_start) begin
      byte_status = frc_pkg::ST_NOT_START;
      fill_next   = '0;
    end else begin
      crc_next  = crc_new;
      fill_next = fill_inc;
      len_next  = len_eff;
      if (fill_inc >= FILL_W'(frc_pkg::LEN_POS)) begin
        if ({1'b0, len_eff} > LEN_LIMIT) begin
          byte_status = frc_pkg::ST_TOO_BIG;
          fill_next   = '0;
        end else if (9'(fill_inc) >= {1'b0, len_eff}) begin
          fill_next = '0;
          if (crc_new != '0) begin
            byte_status = frc_pkg::ST_CRC_BAD;
          end else begin
            good = 1'b1;
          end
        end
      end
    end
  end

  // Push bytes into the cell row; shift zeros in while streaming out
  assign chain_shift = byte_in || emit_step;
  assign chain_din   = byte_in ? in_ch.data_byte : '0;

  frc_chain #(
    .DEPTH(FRAME_BYTES)
  ) u_chain (
    .clk   (clk),
    .shift (chain_shift),
    .din   (chain_din),
    .tap   (tap),
    .dout  (chain_dout)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      idle_count    <= '0;
      running_crc   <= '0;
      timeout_ticks <= frc_pkg::TIMEOUT_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
      if (tick_in && (idle_count != '1)) begin
        idle_count <= idle_count + 1'b1;
      end
      if (byte_in) begin
        idle_count  <= '0;
        fill_count  <= fill_next;
        running_crc <= crc_next;
      end
      unique case (state)
        S_IDLE: begin
          if (byte_in && good) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_step && (emit_idx == tap)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if ((byte_in && !good) || emit_step) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame bookkeeping and output word
  always_ff @(posedge clk) begin
    if (byte_in) begin
      len_reg <= len_next;
    end
    if (byte_in && good) begin
      tap      <= TAP_W'(fill_inc - 1'b1);
      emit_idx <= '0;
    end else if (emit_step) begin
      emit_idx <= emit_idx + 1'b1;
    end
    if (byte_in && !good) begin
      out_status <= byte_status;
      out_byte   <= '0;
      out_index  <= '0;
      out_last   <= 1'b1;
    end else if (emit_step) begin
      out_status <= frc_pkg::ST_GOOD;
      out_byte   <= chain_dout;
      out_index  <= frc_pkg::INDEX_W'(emit_idx);
      out_last   <= (emit_idx == tap);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.frame_byte = out_byte;
  assign out_ch.byte_index = out_index;
  assign out_ch.last       = out_last;

  // Frame never grows past the buffer
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(FRAME_BYTES))
    else $error("fill count beyond buffer depth");

  // Streaming only starts once the frame state is cleared
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (fill_count == '0))
    else $error("frame state not cleared while streaming");

  // A taken good word that is not last is followed by another good word
  a_emit_cont: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && (out_ch.status == frc_pkg::ST_GOOD) && !out_ch.last)
    |=> (out_ch.valid && (out_ch.status == frc_pkg::ST_GOOD)))
    else $error("good frame stream broken");

  // Status words stand alone
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status != frc_pkg::ST_GOOD))
    |-> (out_ch.last && (out_ch.frame_byte == '0) && (state == S_IDLE)))
    else $error("status word malformed");

endmodule
